[design/three_phase_sine_reference_core_defines.svh]
// assertion macros for the three-phase sine reference core
`ifndef THREE_PHASE_SINE_REFERENCE_CORE_DEFINES_SVH
`define THREE_PHASE_SINE_REFERENCE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPSR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpsr assertion failed");
`define TPSR_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("tpsr forbidden condition seen");
`else
`define TPSR_ASSERT(name, prop)
`define TPSR_ASSERT_NEVER(name, expr)
`endif
`endif

[design/tpsr_pkg.sv]
// types, constants and tables for the three-phase sine reference core
`default_nettype none
package tpsr_pkg;

  localparam int unsigned PHASE_BITS_DEF = 32;
  localparam int unsigned OUT_BITS_DEF   = 16;

  localparam int unsigned STEP_W = 24;
  localparam int unsigned FREQ_W = 19;
  localparam int unsigned AMP_W  = 15;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned Z_W    = 31;
  localparam int unsigned COS_W  = 16;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned INC_SHIFT = 8;

  localparam logic [STEP_W-1:0] STEP_RESET     = 24'd429497;
  localparam logic [ANG_W-1:0]  THIRD_TURN     = 32'd1431655765;
  localparam logic [ANG_W-1:0]  TWO_THIRD_TURN = 32'd2863311531;
  localparam logic [ANG_W-1:0]  QUARTER_TURN   = 32'h4000_0000;
  localparam logic [Z_W-1:0]    Z_ONE          = 31'h4000_0000;
  localparam logic [Z_W-1:0]    SIN_COEF_TOP   = 31'd3864;
  localparam logic [18:0]       COS_MAX        = 19'd32767;

  // register map
  localparam logic REG_STEP = 1'b0;

  // phase slots
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  // multiplier passes within one phase
  localparam logic [2:0] K_SQUARE = 3'd0;
  localparam logic [2:0] K_POLY_LAST = 3'd5;
  localparam logic [2:0] K_SINE   = 3'd6;
  localparam logic [2:0] K_SCALE  = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC_MUL,
    S_INC_ADD,
    S_ZPREP,
    S_MUL,
    S_UPD,
    S_DONE
  } state_e;

  // odd taylor coefficients of sin(pi/2 z) in q30, index = power / 2
  function automatic logic [Z_W-1:0] sin_coef(input logic [2:0] idx);
    logic [Z_W-1:0] c;
    case (idx)
      3'd0:    c = 31'd1686629713;
      3'd1:    c = 31'd693598668;
      3'd2:    c = 31'd85569306;
      3'd3:    c = 31'd5026995;
      3'd4:    c = 31'd172272;
      3'd5:    c = SIN_COEF_TOP;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [ANG_W-1:0] phase_offset(input logic [1:0] ph);
    logic [ANG_W-1:0] o;
    case (ph)
      PH_A:    o = '0;
      PH_B:    o = THIRD_TURN;
      PH_C:    o = TWO_THIRD_TURN;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

[design/three_phase_sine_reference_core.sv]
// an accepted input transaction runs the phase step, then phases a, b and c in turn, then loads the output register
// no new input transaction is taken until the last one has reached the output register; the work is
// 25 passes through the one shared 33x33 multiplier (phase step plus eight per phase)
// a finished result waits in the output register while the next transaction runs
// reset: phase accumulator cleared, step register to 429497, no result pending
`default_nettype none
`include "three_phase_sine_reference_core_defines.svh"
module three_phase_sine_reference_core #(
  parameter int unsigned PHASE_BITS = tpsr_pkg::PHASE_BITS_DEF,
  parameter int unsigned OUT_BITS   = tpsr_pkg::OUT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [tpsr_pkg::FREQ_W-1:0] freq_i,
  input  logic [tpsr_pkg::AMP_W-1:0]         amp_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [OUT_BITS-1:0]         phase_a_voltage_o,
  output logic signed [OUT_BITS-1:0]         phase_b_voltage_o,
  output logic signed [OUT_BITS-1:0]         phase_c_voltage_o
);
  import tpsr_pkg::*;

  localparam int unsigned SHIFT_OUT = 31 - OUT_BITS;
  localparam logic signed [PROD_W-1:0] OUT_LIM =
    (PROD_W'(1) << (OUT_BITS - 1)) - PROD_W'(1);

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic out_valid_q, out_valid_d;

  logic signed [FREQ_W-1:0] freq_q, freq_d;
  logic [AMP_W-1:0] amp_q, amp_d;
  logic [1:0] ph_q, ph_d;
  logic [2:0] k_q, k_d;
  logic [Z_W-1:0] z_q, z_d, z2_q, z2_d, p_q, p_d;
  logic neg_q, neg_d;
  logic signed [COS_W-1:0] cos_q, cos_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [OUT_BITS-1:0] res_a_q, res_a_d, res_b_q, res_b_d, res_c_q, res_c_d;
  logic signed [OUT_BITS-1:0] out_a_q, out_a_d, out_b_q, out_b_d, out_c_q, out_c_d;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] inc_full, scaled;
  logic [PHASE_BITS+ANG_W-1:0] ang_ext;
  logic [ANG_W-1:0] ang, bang;
  logic [Z_W-1:0] z_new, hi;
  logic [Z_W:0] poly;
  logic [32:0] s_raw;
  logic [33:0] s_sum;
  logic [18:0] s_rnd;
  logic [14:0] s_mag;
  logic signed [OUT_BITS-1:0] val;
  logic in_acc, out_acc, cfg_wr;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // shared multiplier
  always_comb begin
    if (state_q == S_INC_MUL) begin
      mul_a = MUL_W'(freq_q);
      mul_b = $signed({{(MUL_W-STEP_W){1'b0}}, step_q});
    end else begin
      case (k_q)
        K_SQUARE: begin
          mul_a = $signed({2'b0, z_q});
          mul_b = $signed({2'b0, z_q});
        end
        K_SINE: begin
          mul_a = $signed({2'b0, p_q});
          mul_b = $signed({2'b0, z_q});
        end
        K_SCALE: begin
          mul_a = $signed({{(MUL_W-AMP_W){1'b0}}, amp_q});
          mul_b = MUL_W'(cos_q);
        end
        default: begin
          mul_a = $signed({2'b0, p_q});
          mul_b = $signed({2'b0, z2_q});
        end
      endcase
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // datapath helpers
  always_comb begin
    inc_full = prod_q >>> INC_SHIFT;
    ang_ext  = {phase_q, {ANG_W{1'b0}}};
    ang      = ang_ext[PHASE_BITS+ANG_W-1 -: ANG_W];
    bang     = ang - phase_offset(ph_q) + QUARTER_TURN;
    z_new    = bang[30] ? (Z_ONE - {1'b0, bang[29:0]}) : {1'b0, bang[29:0]};
    hi       = prod_q[60:30];
    poly     = {1'b0, sin_coef(3'(K_POLY_LAST - k_q))} - {1'b0, hi};
    s_raw    = prod_q[62:30];
    s_sum    = {1'b0, s_raw} + 34'h4000;
    s_rnd    = s_sum[33:15];
    s_mag    = (s_rnd > COS_MAX) ? COS_MAX[14:0] : s_rnd[14:0];
    scaled   = prod_q >>> SHIFT_OUT;
    if (scaled > OUT_LIM) begin
      val = OUT_LIM[OUT_BITS-1:0];
    end else if (scaled < -OUT_LIM) begin
      val = -OUT_LIM[OUT_BITS-1:0];
    end else begin
      val = scaled[OUT_BITS-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    freq_d      = freq_q;
    amp_d       = amp_q;
    ph_d        = ph_q;
    k_d         = k_q;
    z_d         = z_q;
    z2_d        = z2_q;
    p_d         = p_q;
    neg_d       = neg_q;
    cos_d       = cos_q;
    prod_d      = prod_q;
    res_a_d     = res_a_q;
    res_b_d     = res_b_q;
    res_c_d     = res_c_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_c_d     = out_c_q;

    if (cfg_wr && paddr[2] == REG_STEP) begin
      step_d = pwdata[STEP_W-1:0];
    end
    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          freq_d  = freq_i;
          amp_d   = amp_i;
          state_d = S_INC_MUL;
        end
      end
      S_INC_MUL: begin
        prod_d  = mul_p;
        state_d = S_INC_ADD;
      end
      S_INC_ADD: begin
        phase_d = phase_q + inc_full[PHASE_BITS-1:0];
        ph_d    = PH_A;
        state_d = S_ZPREP;
      end
      S_ZPREP: begin
        z_d     = z_new;
        neg_d   = bang[31];
        p_d     = SIN_COEF_TOP;
        k_d     = K_SQUARE;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = mul_p;
        state_d = S_UPD;
      end
      S_UPD: begin
        case (k_q)
          K_SQUARE: z2_d = hi;
          K_SINE:   cos_d = neg_q ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
          K_SCALE: begin
            case (ph_q)
              PH_A:    res_a_d = val;
              PH_B:    res_b_d = val;
              default: res_c_d = val;
            endcase
          end
          default:  p_d = poly[Z_W-1:0];
        endcase
        if (k_q == K_SCALE) begin
          if (ph_q == PH_C) begin
            state_d = S_DONE;
          end else begin
            ph_d    = ph_q + 2'd1;
            state_d = S_ZPREP;
          end
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_acc) begin
          out_a_d     = res_a_q;
          out_b_d     = res_b_q;
          out_c_d     = res_c_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      ph_q        <= PH_A;
      k_q         <= K_SQUARE;
    end else begin
      step_q      <= step_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      ph_q        <= ph_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q  <= freq_d;
    amp_q   <= amp_d;
    z_q     <= z_d;
    z2_q    <= z2_d;
    p_q     <= p_d;
    neg_q   <= neg_d;
    cos_q   <= cos_d;
    prod_q  <= prod_d;
    res_a_q <= res_a_d;
    res_b_q <= res_b_d;
    res_c_q <= res_c_d;
    out_a_q <= out_a_d;
    out_b_q <= out_b_d;
    out_c_q <= out_c_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign phase_a_voltage_o = out_a_q;
  assign phase_b_voltage_o = out_b_q;
  assign phase_c_voltage_o = out_c_q;
  assign pready            = 1'b1;
  assign prdata            = (paddr[2] == REG_STEP) ? {{(32-STEP_W){1'b0}}, step_q} : '0;

  `TPSR_ASSERT(a_accept_starts_step, in_acc |=> state_q == S_INC_MUL)
  `TPSR_ASSERT_NEVER(a_phase_slot_range, ph_q == 2'd3)
  `TPSR_ASSERT(a_last_pass_done, state_q == S_UPD && k_q == K_SCALE && ph_q == PH_C |=> state_q == S_DONE)
  `TPSR_ASSERT(a_done_loads_output, state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)

endmodule
`default_nettype wire

[sim/tb_three_phase_sine_reference_core.sv]
// self-checking testbench for the three-phase sine reference core
`timescale 1ns / 1ps
module tb_three_phase_sine_reference_core;
  import tpsr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_PER_SETTING = 320;
  localparam int N_DIRECTED = 20;
  localparam int N_SETTINGS = 6;
  localparam logic [2:0] ADDR_STEP = {REG_STEP, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam logic signed [FREQ_W-1:0] FREQ_MIN = -19'sd262144;
  localparam logic signed [FREQ_W-1:0] FREQ_MAX = 19'sd262143;
  localparam logic [AMP_W-1:0] AMP_FULL = 15'd32767;
  localparam longint VOLT_LIMIT = 32767;

  localparam logic [63:0] SINE_TAYLOR [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } volts_t;

  typedef struct packed {
    logic signed [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]         amp;
    logic                     typed;
    volts_t                   volts;
  } tick_row_t;

  localparam tick_row_t DIRECTED [N_DIRECTED] = '{
    '{19'sd0,       15'd32767,  1'b1, '{16'sd32766, -16'sd16384, -16'sd16384}},
    '{19'sd0,       15'd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0}},
    '{19'sd0,       15'd1,      1'b1, '{16'sd0, -16'sd1, -16'sd1}},
    '{FREQ_MIN,     15'd32767,  1'b0, '0},
    '{FREQ_MAX,     15'd32767,  1'b0, '0},
    '{19'sd256,     15'd16384,  1'b0, '0},
    '{-19'sd256,    15'd16384,  1'b0, '0},
    '{-19'sd1,      15'd32767,  1'b0, '0},
    '{19'sd1,       15'd32767,  1'b0, '0},
    '{19'sd12800,   15'd32767,  1'b0, '0},
    '{19'sd12800,   15'd32767,  1'b0, '0},
    '{19'sd12800,   15'd32767,  1'b0, '0},
    '{19'sh2AAAA,   15'h5555,   1'b0, '0},
    '{19'sh55555,   15'h2AAA,   1'b0, '0},
    '{19'sd0,       15'd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0}},
    '{FREQ_MAX,     15'd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0}},
    '{FREQ_MIN,     15'd1,      1'b0, '0},
    '{19'sd100000,  15'd20000,  1'b0, '0},
    '{-19'sd100000, 15'd32767,  1'b0, '0},
    '{19'sd0,       15'd32767,  1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [FREQ_W-1:0] freq_i = '0;
  logic [AMP_W-1:0] amp_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] phase_a_voltage_o;
  logic signed [15:0] phase_b_voltage_o;
  logic signed [15:0] phase_c_voltage_o;

  three_phase_sine_reference_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .freq_i, .amp_i,
    .out_valid_o, .out_stall_i, .phase_a_voltage_o, .phase_b_voltage_o, .phase_c_voltage_o
  );

  logic [31:0] phase_acc;
  logic [STEP_W-1:0] step_reg;
  volts_t pending_volts[$];
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_mode = 0;
  int stall_span = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    mismatches++;
  endtask

  // cosine in q15 from sin over a quarter turn, z in q30
  function automatic int cos_q15(input logic [31:0] ang);
    logic [31:0] b;
    logic [63:0] z, z2, p, s;
    int k;
    b = ang + QUARTER_TURN;
    z = b[30] ? ((64'd1 << 30) - {34'd0, b[29:0]}) : {34'd0, b[29:0]};
    z2 = (z * z) >> 30;
    p = SINE_TAYLOR[5];
    for (k = 4; k >= 0; k--)
      p = SINE_TAYLOR[k] - ((p * z2) >> 30);
    s = (((p * z) >> 30) + (64'd1 << 14)) >> 15;
    if (s > 64'd32767)
      s = 64'd32767;
    return b[31] ? -int'(s) : int'(s);
  endfunction

  function automatic logic signed [15:0] scale_volt(input logic [AMP_W-1:0] a,
                                                     input logic [31:0] ang);
    longint amp_l, prod, v;
    amp_l = a;
    prod = amp_l * longint'(cos_q15(ang));
    v = prod >>> 15;
    if (v > VOLT_LIMIT)
      v = VOLT_LIMIT;
    if (v < -VOLT_LIMIT)
      v = -VOLT_LIMIT;
    return v[15:0];
  endfunction

  function automatic volts_t advance_phase(input logic signed [FREQ_W-1:0] f,
                                           input logic [AMP_W-1:0] a);
    longint hz, st, inc;
    volts_t v;
    hz = f;
    st = step_reg;
    inc = (hz * st) >>> INC_SHIFT;
    phase_acc = phase_acc + inc[31:0];
    v.a = scale_volt(a, phase_acc);
    v.b = scale_volt(a, phase_acc - THIRD_TURN);
    v.c = scale_volt(a, phase_acc - TWO_THIRD_TURN);
    return v;
  endfunction

  task automatic send_tick(input logic signed [FREQ_W-1:0] f, input logic [AMP_W-1:0] a,
                           input logic use_typed, input volts_t typed_volts);
    int gap;
    volts_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    freq_i <= f;
    amp_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    want = advance_phase(f, a);
    pending_volts.push_back(use_typed ? typed_volts : want);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (wr && addr == ADDR_STEP)
      step_reg = data[STEP_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_step_readback();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_STEP, '0, rd);
    if (rd[STEP_W-1:0] !== step_reg)
      report_mismatch("step register readback", rd[STEP_W-1:0], step_reg);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_volts.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_tick();
    logic signed [FREQ_W-1:0] f;
    logic [AMP_W-1:0] a;
    int kind;
    kind = $urandom_range(0, 9);
    f = FREQ_W'($urandom);
    a = AMP_W'($urandom_range(0, 32767));
    case (kind)
      0: begin
        case ($urandom_range(0, 4))
          0: f = FREQ_MIN;
          1: f = FREQ_MAX;
          2: f = '0;
          3: f = -19'sd1;
          default: f = 19'sd1;
        endcase
      end
      1: a = ($urandom_range(0, 2) == 0) ? 15'd0 : ($urandom_range(0, 1) ? AMP_FULL : 15'd1);
      2, 3, 4: ;
      default: f = FREQ_W'($urandom_range(0, 51200) - 25600);
    endcase
    send_tick(f, a, 1'b0, '0);
  endtask

  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(30, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= stall_span[4];
    endcase
  end

  always @(posedge clk_i) begin : check_volts
    volts_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_volts.size() == 0) begin
        report_mismatch("unexpected result transaction", phase_a_voltage_o, 0);
      end else begin
        want = pending_volts.pop_front();
        if (phase_a_voltage_o !== want.a)
          report_mismatch("phase a voltage", phase_a_voltage_o, want.a);
        if (phase_b_voltage_o !== want.b)
          report_mismatch("phase b voltage", phase_b_voltage_o, want.b);
        if (phase_c_voltage_o !== want.c)
          report_mismatch("phase c voltage", phase_c_voltage_o, want.c);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [23:0] step_plan [N_SETTINGS];
    logic [31:0] rd;
    int s;
    int i;
    phase_acc = '0;
    step_reg = STEP_RESET;
    // zero step freezes the phase, then the extremes of the register
    step_plan = '{24'd0, 24'hFFFFFF, 24'd1, 24'($urandom_range(1, 16777215)), STEP_RESET,
                  24'($urandom_range(1, 4096))};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_step_readback();
    for (i = 0; i < N_DIRECTED; i++)
      send_tick(DIRECTED[i].freq, DIRECTED[i].amp, DIRECTED[i].typed, DIRECTED[i].volts);

    for (s = 0; s < N_SETTINGS; s++) begin
      wait_drained();
      apb_access(1'b1, ADDR_STEP, {8'd0, step_plan[s]}, rd);
      if (s == 2)
        apb_access(1'b1, ADDR_UNMAPPED, $urandom, rd);
      check_step_readback();
      gaps_on = (s != 1);
      for (i = 0; i < RANDOM_PER_SETTING; i++)
        random_tick();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
